// ===== sv/fmc_pkg.sv =====
// shared types, constants and helpers for the frame motion complexity unit
`timescale 1ns / 1ps

package fmc_pkg;

    // frame geometry bounds, used only for the per-frame sample cap
    localparam int MAX_LINE = 4096;
    localparam int MAX_ROWS = 4096;
    localparam longint CAP_RAW = longint'(MAX_LINE) * longint'(MAX_ROWS);
    localparam longint CAP_LIMIT = 64'd16777216;

    // item field widths
    localparam int LUMA_W  = 8;
    localparam int STEP_W  = 5;
    localparam int PHASE_W = 4;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W   = 32;
    localparam int COUNT_W = 25;
    localparam int TALLY_W = 16;
    localparam int MAD_W   = 16;
    localparam int SCORE_W = 17;
    localparam int QSTEP_W = 6;
    localparam int THR_W   = 26;
    localparam int PERMILLE_W = 10;

    localparam logic [COUNT_W-1:0] SAMPLE_CAP =
        (CAP_RAW > CAP_LIMIT) ? COUNT_W'(CAP_LIMIT) : COUNT_W'(CAP_RAW);

    // packed stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // shared divider: one quotient bit per cycle
    localparam int DIV_N_W   = 40;
    localparam int DIV_D_W   = 25;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // item codes
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_FINISH  = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE     = 2'd2;

    localparam logic [STEP_W-1:0] RESET_STEP       = 5'd4;
    localparam logic [CFG_W-1:0]  RESET_MIN_SAMPLE = 8'd3;
    localparam logic [CFG_W-1:0]  RESET_FULL_SCALE = 8'd50;
    localparam logic [STEP_W-1:0] STEP_MAX         = 5'd16;

    // fallback report values
    localparam logic [MAD_W-1:0]   FALLBACK_AVG   = 16'd6400;
    localparam logic [SCORE_W-1:0] FALLBACK_SCORE = 17'd32768;
    localparam logic [QSTEP_W-1:0] FALLBACK_STEP  = 6'd24;
    localparam logic [SCORE_W-1:0] SCORE_ONE      = 17'd65536;
    localparam logic [TALLY_W-1:0] TALLY_MAX      = 16'hFFFF;

    // quality step thresholds in thousandths of full scale
    localparam int NUM_STEPS = 5;
    localparam logic [PERMILLE_W-1:0] STEP_PERMILLE [NUM_STEPS] =
        '{10'd40, 10'd100, 10'd200, 10'd350, 10'd550};
    localparam logic [QSTEP_W-1:0] STEP_VALUE [NUM_STEPS+1] =
        '{6'd32, 6'd30, 6'd28, 6'd26, 6'd24, 6'd22};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAD_START,
        ST_MAD_WAIT,
        ST_AVG_WAIT,
        ST_SCORE_START,
        ST_SCORE_WAIT,
        ST_EMIT
    } fmc_state_t;

    typedef struct packed {
        logic pixel;        // pixel item taken
        logic finish;       // finish item taken
        logic mad_start;    // start frame mad division
        logic mad_done;     // frame mad quotient ready
        logic avg_done;     // average quotient ready
        logic score_start;  // start score division
        logic score_done;   // score quotient ready
        logic emit;         // move result into output register
    } fmc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic fallback;
        logic out_free;
    } fmc_status_t;

    // permille * fs * 256, compared against avg * 1000
    function automatic logic [THR_W-1:0] step_threshold(
        input logic [PERMILLE_W-1:0] permille,
        input logic [CFG_W-1:0]      fs
    );
        return (THR_W'(permille) * THR_W'(fs)) << 8;
    endfunction

endpackage

// ===== sv/fmc_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fmc_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fmc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [fmc_pkg::DIV_D_W-1:0]  divisor,
    output logic                         done,
    output logic [fmc_pkg::DIV_N_W-1:0]  quotient
);
    import fmc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   n_reg, n_next;
    logic [DIV_D_W-1:0]   d_reg, d_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W:0]     rem_shift;
    logic [DIV_D_W:0]     rem_sub;
    logic                 fits;

    assign rem_shift = {rem_reg, n_reg[DIV_N_W-1]};
    assign rem_sub   = rem_shift - {1'b0, d_reg};
    assign fits      = (rem_shift >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = dividend;
            d_next    = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where dividend bits leave
            n_next   = {n_reg[DIV_N_W-2:0], fits};
            rem_next = fits ? rem_sub[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule

// ===== sv/fmc_datapath.sv =====
// accumulators, config registers, result and output registers
`timescale 1ns / 1ps

module fmc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmc_pkg::CFG_W-1:0]      cfg_data,
    input  logic [fmc_pkg::LUMA_W-1:0]     luma_prev,
    input  logic [fmc_pkg::LUMA_W-1:0]     luma_cur,
    input  logic                           end_of_line,
    input  logic                           end_of_frame,
    input  fmc_pkg::fmc_cmd_t              cmd,
    output fmc_pkg::fmc_status_t           status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fmc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);
    import fmc_pkg::*;

    // configuration
    logic [STEP_W-1:0]  step_cfg_reg;
    logic [CFG_W-1:0]   min_samples_reg;
    logic [CFG_W-1:0]   full_scale_reg;

    // accumulators
    logic [SUM_W-1:0]   diff_sum_reg, diff_sum_next;
    logic [COUNT_W-1:0] pixel_count_reg, pixel_count_next;
    logic [PHASE_W-1:0] col_phase_reg, col_phase_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [SUM_W-1:0]   mad_total_reg, mad_total_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;

    // pending result
    logic               res_kind_reg, res_kind_next;
    logic [MAD_W-1:0]   res_mad_reg, res_mad_next;
    logic [MAD_W-1:0]   res_avg_reg, res_avg_next;
    logic [SCORE_W-1:0] res_score_reg, res_score_next;
    logic [QSTEP_W-1:0] res_qstep_reg, res_qstep_next;
    logic               res_fb_reg, res_fb_next;
    logic [TALLY_W-1:0] res_frames_reg, res_frames_next;
    logic [THR_W-1:0]   avg_k_reg, avg_k_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_user_reg, out_user_next;

    logic [STEP_W-1:0]   step_eff;
    logic [CFG_W-1:0]    fs_eff;
    logic [LUMA_W-1:0]   abs_diff;
    logic                keep;
    logic [STEP_W-1:0]   col_inc, row_inc;
    logic [PHASE_W-1:0]  col_adv, row_adv;
    logic                fallback;
    logic [MAD_W-1:0]    frame_mad;
    logic [QSTEP_W-1:0]  qstep;
    logic [SCORE_W-1:0]  score_sat;

    logic                div_start;
    logic [DIV_N_W-1:0]  div_n;
    logic [DIV_D_W-1:0]  div_d;
    logic                div_done;
    logic [DIV_N_W-1:0]  div_q;

    fmc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // out-of-range steps fold into 1..16, zero full scale acts as one
    assign step_eff = (step_cfg_reg == '0) ? STEP_W'(1) :
                      (step_cfg_reg > STEP_MAX) ? STEP_MAX : step_cfg_reg;
    assign fs_eff   = (full_scale_reg == '0) ? CFG_W'(1) : full_scale_reg;

    assign abs_diff = (luma_prev > luma_cur) ? (luma_prev - luma_cur)
                                             : (luma_cur - luma_prev);
    assign keep     = (col_phase_reg == '0) && (row_phase_reg == '0) &&
                      (pixel_count_reg < SAMPLE_CAP);

    assign col_inc  = {1'b0, col_phase_reg} + STEP_W'(1);
    assign row_inc  = {1'b0, row_phase_reg} + STEP_W'(1);
    assign col_adv  = (col_inc >= step_eff) ? '0 : col_inc[PHASE_W-1:0];
    assign row_adv  = (row_inc >= step_eff) ? '0 : row_inc[PHASE_W-1:0];

    assign fallback = (tally_reg == '0) || (tally_reg < TALLY_W'(min_samples_reg));

    assign frame_mad = (pixel_count_reg == '0) ? '0 : div_q[MAD_W-1:0];
    assign score_sat = (div_q > DIV_N_W'(SCORE_ONE)) ? SCORE_ONE : div_q[SCORE_W-1:0];

    // lowest threshold that the average falls under picks the step
    always_comb
    begin
        qstep = STEP_VALUE[NUM_STEPS];
        for (int k = NUM_STEPS - 1; k >= 0; k--)
        begin
            if (avg_k_reg < step_threshold(STEP_PERMILLE[k], fs_eff))
            begin
                qstep = STEP_VALUE[k];
            end
        end
    end

    // divider operand select
    always_comb
    begin
        div_start = cmd.mad_start || cmd.score_start || (cmd.finish && !fallback);
        if (cmd.mad_start)
        begin
            div_n = {diff_sum_reg, 8'd0} + DIV_N_W'(pixel_count_reg >> 1);
            div_d = pixel_count_reg;
        end
        else if (cmd.score_start)
        begin
            div_n = {16'd0, res_avg_reg, 8'd0} + DIV_N_W'(fs_eff >> 1);
            div_d = DIV_D_W'(fs_eff);
        end
        else
        begin
            div_n = DIV_N_W'(mad_total_reg) + DIV_N_W'(tally_reg >> 1);
            div_d = DIV_D_W'(tally_reg);
        end
    end

    always_comb
    begin
        diff_sum_next    = diff_sum_reg;
        pixel_count_next = pixel_count_reg;
        col_phase_next   = col_phase_reg;
        row_phase_next   = row_phase_reg;
        mad_total_next   = mad_total_reg;
        tally_next       = tally_reg;

        res_kind_next    = res_kind_reg;
        res_mad_next     = res_mad_reg;
        res_avg_next     = res_avg_reg;
        res_score_next   = res_score_reg;
        res_qstep_next   = res_qstep_reg;
        res_fb_next      = res_fb_reg;
        res_frames_next  = res_frames_reg;
        avg_k_next       = avg_k_reg;

        if (cmd.pixel)
        begin
            if (keep)
            begin
                diff_sum_next    = diff_sum_reg + SUM_W'(abs_diff);
                pixel_count_next = pixel_count_reg + COUNT_W'(1);
            end
            if (end_of_frame)
            begin
                col_phase_next = '0;
                row_phase_next = '0;
            end
            else if (end_of_line)
            begin
                col_phase_next = '0;
                row_phase_next = row_adv;
            end
            else
            begin
                col_phase_next = col_adv;
            end
        end

        if (cmd.mad_done)
        begin
            if (tally_reg != TALLY_MAX)
            begin
                mad_total_next = mad_total_reg + SUM_W'(frame_mad);
                tally_next     = tally_reg + TALLY_W'(1);
            end
            diff_sum_next    = '0;
            pixel_count_next = '0;
            res_kind_next    = KIND_FRAME;
            res_mad_next     = frame_mad;
            res_avg_next     = '0;
            res_score_next   = '0;
            res_qstep_next   = '0;
            res_fb_next      = 1'b0;
            res_frames_next  = tally_next;
        end

        if (cmd.finish)
        begin
            // divider has already sampled the totals when they clear
            res_kind_next   = KIND_FINAL;
            res_mad_next    = '0;
            res_avg_next    = FALLBACK_AVG;
            res_score_next  = FALLBACK_SCORE;
            res_qstep_next  = FALLBACK_STEP;
            res_fb_next     = fallback;
            res_frames_next = tally_reg;
            mad_total_next  = '0;
            tally_next      = '0;
        end

        if (cmd.avg_done)
        begin
            res_avg_next = div_q[MAD_W-1:0];
            avg_k_next   = THR_W'(div_q[MAD_W-1:0]) * THR_W'(1000);
        end

        if (cmd.score_done)
        begin
            res_score_next = score_sat;
            res_qstep_next = qstep;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_user_next  = res_kind_reg;
            out_data_next  = {res_frames_reg, res_fb_reg, res_qstep_reg,
                              res_score_reg, res_avg_reg, res_mad_reg};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg    <= RESET_STEP;
            min_samples_reg <= RESET_MIN_SAMPLE;
            full_scale_reg  <= RESET_FULL_SCALE;
            diff_sum_reg    <= '0;
            pixel_count_reg <= '0;
            col_phase_reg   <= '0;
            row_phase_reg   <= '0;
            mad_total_reg   <= '0;
            tally_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SUBSAMPLE_STEP: step_cfg_reg    <= cfg_data[STEP_W-1:0];
                    CFG_MIN_SAMPLES:    min_samples_reg <= cfg_data;
                    CFG_FULL_SCALE:     full_scale_reg  <= cfg_data;
                    default:            ;
                endcase
            end
            diff_sum_reg    <= diff_sum_next;
            pixel_count_reg <= pixel_count_next;
            col_phase_reg   <= col_phase_next;
            row_phase_reg   <= row_phase_next;
            mad_total_reg   <= mad_total_next;
            tally_reg       <= tally_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg   <= res_kind_next;
        res_mad_reg    <= res_mad_next;
        res_avg_reg    <= res_avg_next;
        res_score_reg  <= res_score_next;
        res_qstep_reg  <= res_qstep_next;
        res_fb_reg     <= res_fb_next;
        res_frames_reg <= res_frames_next;
        avg_k_reg      <= avg_k_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    assign status.div_done = div_done;
    assign status.fallback = fallback;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== sv/fmc_controller.sv =====
// sequencing state machine for item acceptance, divisions and result hand-off
`timescale 1ns / 1ps

module fmc_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  op,
    input  logic                  end_of_frame,
    input  fmc_pkg::fmc_status_t  status,
    output fmc_pkg::fmc_cmd_t     cmd
);
    import fmc_pkg::*;

    fmc_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (op == OP_FINISH)
                    begin
                        state_next = status.fallback ? ST_EMIT : ST_AVG_WAIT;
                    end
                    else if (end_of_frame)
                    begin
                        state_next = ST_MAD_START;
                    end
                end
            end
            ST_MAD_START:   state_next = ST_MAD_WAIT;
            ST_MAD_WAIT:    state_next = status.div_done ? ST_EMIT : ST_MAD_WAIT;
            ST_AVG_WAIT:    state_next = status.div_done ? ST_SCORE_START : ST_AVG_WAIT;
            ST_SCORE_START: state_next = ST_SCORE_WAIT;
            ST_SCORE_WAIT:  state_next = status.div_done ? ST_EMIT : ST_SCORE_WAIT;
            ST_EMIT:        state_next = status.out_free ? ST_IDLE : ST_EMIT;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.pixel  = s_tvalid && (op == OP_PIXEL);
                cmd.finish = s_tvalid && (op == OP_FINISH);
            end
            ST_MAD_START:   cmd.mad_start   = 1'b1;
            ST_MAD_WAIT:    cmd.mad_done    = status.div_done;
            ST_AVG_WAIT:    cmd.avg_done    = status.div_done;
            ST_SCORE_START: cmd.score_start = 1'b1;
            ST_SCORE_WAIT:  cmd.score_done  = status.div_done;
            ST_EMIT:        cmd.emit        = status.out_free;
            default:        ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/frame_motion_complexity_unit.sv =====
// frame motion complexity unit: subsampled luma mad per frame and final complexity score
// pixel item without frame end: taken while idle, the next item may follow at once
// frame end item: MAD_START and MAD_WAIT run the mad division, EMIT loads the report, then
// IDLE takes the next item; finish item: AVG_WAIT, SCORE_START, SCORE_WAIT, EMIT, or EMIT alone
// on fallback; a stalled output register adds its wait; reset (rst_n, asynchronous, active low)
// clears accumulators, phases and the output register and loads the register defaults
`timescale 1ns / 1ps

module frame_motion_complexity_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [fmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmc_pkg::CFG_W-1:0]      cfg_data,
    // input item stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fmc_pkg::S_TDATA_W-1:0]  s_tdata,   // luma_prev, luma_cur, end_of_line, zero pad
    input  logic                           s_tlast,   // end_of_frame
    input  logic                           s_tuser,   // op
    // result item stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fmc_pkg::M_TDATA_W-1:0]  m_tdata,   // frame_mad, average_mad, score,
                                                      // quality_step, fallback, frames_compared
    output logic                           m_tuser    // kind
);
    import fmc_pkg::*;

    fmc_cmd_t    cmd;
    fmc_status_t status;

    // input item fields
    logic [LUMA_W-1:0] luma_prev;
    logic [LUMA_W-1:0] luma_cur;
    logic              end_of_line;

    assign luma_prev   = s_tdata[LUMA_W-1:0];
    assign luma_cur    = s_tdata[2*LUMA_W-1:LUMA_W];
    assign end_of_line = s_tdata[2*LUMA_W];

    // controller: accepts items only when idle, walks the divisions, waits
    // for the output register before handing the pending result over
    fmc_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .op           (s_tuser),
        .end_of_frame (s_tlast),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath: subsampling phases, per-frame sums, frame mad totals,
    // shared divider, quality step compare and the output register
    fmc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .luma_prev    (luma_prev),
        .luma_cur     (luma_cur),
        .end_of_line  (end_of_line),
        .end_of_frame (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // final reports carry no frame mad
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_FINAL)) |-> (m_tdata[15:0] == 16'd0))
        else $error("final report with nonzero frame mad");

    // frame reports carry no average, score, step or fallback
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_FRAME)) |-> (m_tdata[55:16] == 40'd0))
        else $error("frame report with score fields set");

    // score never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[48:32] <= SCORE_ONE))
        else $error("score above one");

    // final quality step is one of the encoder steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_FINAL)) |->
            ((m_tdata[54:49] == 6'd32) || (m_tdata[54:49] == 6'd30) ||
             (m_tdata[54:49] == 6'd28) || (m_tdata[54:49] == 6'd26) ||
             (m_tdata[54:49] == 6'd24) || (m_tdata[54:49] == 6'd22)))
        else $error("illegal quality step");

    // a frame mad division start always comes from a taken frame end item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mad_start |-> $past(s_tvalid && s_tready && s_tlast && !s_tuser))
        else $error("frame division without frame end");

endmodule
